// ===== hdl/dppi_pkg.sv =====
// ----------------------------------------------------------------------------
// dppi_pkg
// Shared types and constants of the dual-polarization power integrator.
// ----------------------------------------------------------------------------
package dppi_pkg;

	localparam int MAX_CHANNELS = 1024;
	localparam int CH_W = 10;
	localparam int ADDR_W = 11;
	localparam int ACC_W = 24;
	localparam int CNT_W = 17;
	localparam int CFG_W = 11;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [3:0] NIB_BIAS = 4'd8;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic [7:0] sample_byte;
		logic polarization;
		logic [CH_W-1:0] channel_index;
		logic packet_invalid;
		logic last_packet;
	} in_item_t;

	typedef struct packed {
		logic out_polarization;
		logic [CH_W-1:0] out_channel;
		logic [ACC_W-1:0] mean_power;
		logic no_valid_packets;
	} out_item_t;

	// Classified work handed from front to back.
	typedef struct packed {
		logic pol;
		logic [CH_W-1:0] ch;
		logic [7:0] power;
		logic add;
		logic report;
		logic [CNT_W-1:0] cnt;
	} work_t;

	// Square of a biased nibble; the largest magnitude is 8, giving 64.
	function automatic logic [6:0] nib_sq(input logic [3:0] nib);
		logic [3:0] mag;
		mag = (nib >= NIB_BIAS) ? nib - NIB_BIAS : NIB_BIAS - nib;
		return {3'b000, mag} * {3'b000, mag};
	endfunction

endpackage

// ===== hdl/dppi_if.sv =====
// ----------------------------------------------------------------------------
// dppi_in_if / dppi_out_if
// Valid/ready channels carrying input samples and mean-power results.
// ----------------------------------------------------------------------------
interface dppi_in_if;
	logic valid;
	logic ready;
	dppi_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dppi_out_if;
	logic valid;
	logic ready;
	dppi_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/dual_pol_power_integrator.sv =====
// ----------------------------------------------------------------------------
// dual_pol_power_integrator
// Per-polarization, per-channel power integration of 4-bit complex samples.
// ----------------------------------------------------------------------------
// A front part accepts one sample item per cycle, while its four-entry queue
// is not full, dropping inactive channels and keeping the valid-packet counts.
// The back part performs an accumulator read-modify-write per item (24-bit
// memory, registered read) and pops the next item only after the write of
// the last. An item of the last packet with a nonzero count additionally runs
// a bit-serial divider; its result goes to the out_q staging register and is
// then loaded into the output register once that register is free. After reset
// the back part clears the 2048-entry accumulator memory; input items queue but
// none is processed until the pass ends.
module dual_pol_power_integrator (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dppi_pkg::CFG_W-1:0] cfg_wdata,
	dppi_in_if.sink in_ch,
	dppi_out_if.source out_ch
);

	logic q_valid, q_pop;
	dppi_pkg::work_t q_data;

	dppi_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	dppi_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .out_ch(out_ch)
	);

	// The back part never pops an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");

	// A zero-count result carries a zero mean.
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.no_valid_packets) |-> out_ch.data.mean_power == '0)
		else $error("nonzero mean with no valid packets");

endmodule

// ===== hdl/dppi_front.sv =====
// ----------------------------------------------------------------------------
// dppi_front
// Accepts samples, filters inactive channels, keeps packet counts and pushes
// classified work into a short queue.
// ----------------------------------------------------------------------------
module dppi_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dppi_pkg::CFG_W-1:0] cfg_wdata,
	dppi_in_if.sink in_ch,
	output logic q_valid,
	output dppi_pkg::work_t q_data,
	input logic q_pop
);

	logic [dppi_pkg::CFG_W-1:0] active_q;
	logic [dppi_pkg::CFG_W-1:0] nch;
	logic [dppi_pkg::CNT_W-1:0] cnt_q [2];
	dppi_pkg::work_t fifo_q [dppi_pkg::QDEPTH];
	logic [dppi_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [dppi_pkg::QPTR_W:0] fill_q;
	logic push, active, pol;
	logic [dppi_pkg::CH_W-1:0] ch;
	logic [dppi_pkg::CNT_W-1:0] cnt_new;
	dppi_pkg::work_t w;

	always_comb begin
		nch = active_q;
		if (nch == '0) nch = dppi_pkg::CFG_W'(1);
		if (nch > dppi_pkg::CFG_W'(dppi_pkg::MAX_CHANNELS))
			nch = dppi_pkg::CFG_W'(dppi_pkg::MAX_CHANNELS);
	end

	assign in_ch.ready = (fill_q != (dppi_pkg::QPTR_W+1)'(dppi_pkg::QDEPTH));
	assign pol = in_ch.data.polarization;
	assign ch = in_ch.data.channel_index;
	assign active = ({1'b0, ch} < nch);
	assign push = in_ch.valid && in_ch.ready && active;

	always_comb begin
		cnt_new = cnt_q[pol];
		if (!in_ch.data.packet_invalid && ch == '0 && cnt_new != dppi_pkg::CNT_MAX)
			cnt_new = cnt_new + 1'b1;
		w.pol = pol;
		w.ch = ch;
		w.power = {1'b0, dppi_pkg::nib_sq(in_ch.data.sample_byte[7:4])}
			+ {1'b0, dppi_pkg::nib_sq(in_ch.data.sample_byte[3:0])};
		w.add = !in_ch.data.packet_invalid;
		w.report = in_ch.data.last_packet;
		w.cnt = cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= dppi_pkg::CFG_W'(dppi_pkg::MAX_CHANNELS);
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_we) active_q <= cfg_wdata;
			if (push) begin
				// Count clears once the highest active channel is reported.
				if (in_ch.data.last_packet && {1'b0, ch} == nch - 1'b1)
					cnt_q[pol] <= '0;
				else
					cnt_q[pol] <= cnt_new;
				wp_q <= wp_q + 1'b1;
			end
			if (q_pop) rp_q <= rp_q + 1'b1;
			fill_q <= fill_q + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= w;
	end

	assign q_valid = (fill_q != '0);
	assign q_data = fifo_q[rp_q];

endmodule

// ===== hdl/dppi_div.sv =====
// ----------------------------------------------------------------------------
// dppi_div
// Restoring divider, one quotient bit per cycle: (sum << 16) / cnt, saturated.
// ----------------------------------------------------------------------------
module dppi_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [dppi_pkg::ACC_W-1:0] sum,
	input logic [dppi_pkg::CNT_W-1:0] cnt,
	output logic done,
	output logic [dppi_pkg::ACC_W-1:0] quot
);

	localparam int NUM_W = dppi_pkg::ACC_W + 16;
	localparam int STEP_W = 6;

	logic busy_q;
	logic [NUM_W-1:0] num_q;
	logic [dppi_pkg::CNT_W:0] rem_q;
	logic [dppi_pkg::CNT_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;
	logic [dppi_pkg::CNT_W:0] trial;
	logic [dppi_pkg::CNT_W+1:0] diff;

	assign trial = {rem_q[dppi_pkg::CNT_W-1:0], num_q[NUM_W-1]};
	assign diff = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {sum, 16'b0};
			rem_q <= '0;
			den_q <= cnt;
		end else if (busy_q) begin
			if (!diff[dppi_pkg::CNT_W+1]) begin
				rem_q <= diff[dppi_pkg::CNT_W:0];
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// Quotient bits shift into num_q; any high bit set means saturation.
	assign quot = (num_q[NUM_W-1:dppi_pkg::ACC_W] != '0) ? dppi_pkg::ACC_MAX
		: num_q[dppi_pkg::ACC_W-1:0];

endmodule

// ===== hdl/dppi_back.sv =====
// ----------------------------------------------------------------------------
// dppi_back
// Accumulator memory read-modify-write, clearing pass, and result staging.
// ----------------------------------------------------------------------------
module dppi_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input dppi_pkg::work_t q_data,
	output logic q_pop,
	dppi_out_if.source out_ch
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [dppi_pkg::ACC_W-1:0] mem [2*dppi_pkg::MAX_CHANNELS];
	logic [dppi_pkg::ACC_W-1:0] rdata_q;
	logic [dppi_pkg::ADDR_W:0] clr_q;
	dppi_pkg::work_t cur_q;
	logic [dppi_pkg::ADDR_W-1:0] addr, cur_addr;
	logic [dppi_pkg::ACC_W:0] sum_w;
	logic [dppi_pkg::ACC_W-1:0] sum_sat;
	logic we;
	logic [dppi_pkg::ADDR_W-1:0] waddr;
	logic [dppi_pkg::ACC_W-1:0] wdata;
	logic div_start, div_done;
	logic [dppi_pkg::ACC_W-1:0] quot;
	logic out_full_q;
	logic out_load;
	dppi_pkg::out_item_t out_q;
	dppi_pkg::out_item_t res_q;

	assign addr = {q_data.pol, q_data.ch};
	assign cur_addr = {cur_q.pol, cur_q.ch};
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign sum_w = {1'b0, rdata_q} + (dppi_pkg::ACC_W+1)'(cur_q.power);
	assign sum_sat = sum_w[dppi_pkg::ACC_W] ? dppi_pkg::ACC_MAX : sum_w[dppi_pkg::ACC_W-1:0];
	assign out_load = (state_q == ST_OUT) && (!out_full_q || out_ch.ready);

	always_comb begin
		we = 1'b0;
		waddr = cur_addr;
		wdata = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q[dppi_pkg::ADDR_W-1:0];
			end
			ST_READ: begin
				we = 1'b1;
				if (cur_q.report) begin
					div_start = (cur_q.cnt != '0);
				end else begin
					wdata = cur_q.add ? sum_sat : rdata_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[addr];
		if (q_pop) cur_q <= q_data;
		if (state_q == ST_READ && cur_q.report) begin
			out_q.out_polarization <= cur_q.pol;
			out_q.out_channel <= cur_q.ch;
			out_q.no_valid_packets <= (cur_q.cnt == '0);
			out_q.mean_power <= '0;
		end else if (div_done) begin
			out_q.mean_power <= quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (out_load) out_full_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_full_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (dppi_pkg::ADDR_W+1)'(2*dppi_pkg::MAX_CHANNELS-1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (q_pop) state_q <= ST_READ;
				ST_READ: begin
					if (!cur_q.report) state_q <= ST_IDLE;
					else if (cur_q.cnt != '0) state_q <= ST_DIV;
					else state_q <= ST_OUT;
				end
				ST_DIV: if (div_done) state_q <= ST_OUT;
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The division uses the sum including this sample when its packet is valid.
	dppi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.sum(cur_q.add ? sum_sat : rdata_q), .cnt(cur_q.cnt),
		.done(div_done), .quot(quot)
	);

	// Result register: holds the finished result while the next is prepared.
	always_ff @(posedge clk) begin
		if (out_load) res_q <= out_q;
	end

	assign out_ch.valid = out_full_q;
	assign out_ch.data = res_q;

endmodule

// ===== verif/tb_dual_pol_power_integrator.sv =====
// ----------------------------------------------------------------------------
// tb_dual_pol_power_integrator
// Self-checking testbench for the dual-polarization power integrator. Sample
// items are driven through the input channel with random gaps. Each accepted
// item is run through a behavioral predictor that keeps its own accumulators,
// packet counts and channel setting. The expected mean-power items are queued
// and compared field by field with what leaves the output channel, which is
// stalled at random.
// ----------------------------------------------------------------------------
module tb_dual_pol_power_integrator;
	timeunit 1ns;
	timeprecision 1ps;

	// Queue drain plus one divider pass, with margin.
	localparam int SETTLE_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [dppi_pkg::CFG_W-1:0] cfg_wdata = '0;

	dppi_in_if in_ch ();
	dppi_out_if out_ch ();

	dual_pol_power_integrator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #10 clk = ~clk;

	// Predictor state, kept apart from the block under test.
	logic [dppi_pkg::ACC_W-1:0] power_sum [2*dppi_pkg::MAX_CHANNELS];
	logic [dppi_pkg::CNT_W-1:0] packet_count [2];
	logic [dppi_pkg::CFG_W-1:0] channel_setting;

	dppi_pkg::out_item_t expected_means [$];
	int sent_items = 0;
	int means_seen = 0;
	int mismatches = 0;
	int zero_count_means = 0;
	int saturated_means = 0;
	// When set, both sides run without gaps or stalls.
	bit full_rate = 1'b0;

	// The effective channel count: zero acts as one, the top is clamped.
	function automatic int used_channels();
		int n;
		n = channel_setting;
		if (n == 0) n = 1;
		if (n > dppi_pkg::MAX_CHANNELS) n = dppi_pkg::MAX_CHANNELS;
		return n;
	endfunction

	function automatic int sample_power(input logic [7:0] b);
		int re, im;
		re = int'(b[7:4]) - 8;
		im = int'(b[3:0]) - 8;
		return re*re + im*im;
	endfunction

	// Applies one accepted sample to the predictor and queues a mean if one is due.
	function automatic void integrate_sample(input dppi_pkg::in_item_t s);
		int nch, idx;
		logic [63:0] total, quotient;
		dppi_pkg::out_item_t r;
		nch = used_channels();
		if (s.channel_index >= nch) return;
		idx = s.polarization * dppi_pkg::MAX_CHANNELS + s.channel_index;
		if (!s.packet_invalid) begin
			if (s.channel_index == 0 && packet_count[s.polarization] != dppi_pkg::CNT_MAX)
				packet_count[s.polarization]++;
			total = 64'(power_sum[idx]) + 64'(sample_power(s.sample_byte));
			power_sum[idx] = (total > 64'(dppi_pkg::ACC_MAX)) ? dppi_pkg::ACC_MAX
				: total[dppi_pkg::ACC_W-1:0];
		end
		if (!s.last_packet) return;
		r.out_polarization = s.polarization;
		r.out_channel = s.channel_index;
		if (packet_count[s.polarization] == 0) begin
			r.mean_power = '0;
			r.no_valid_packets = 1'b1;
			zero_count_means++;
		end else begin
			quotient = (64'(power_sum[idx]) << 16) / 64'(packet_count[s.polarization]);
			if (quotient > 64'(dppi_pkg::ACC_MAX)) begin
				quotient = 64'(dppi_pkg::ACC_MAX);
				saturated_means++;
			end
			r.mean_power = quotient[dppi_pkg::ACC_W-1:0];
			r.no_valid_packets = 1'b0;
		end
		expected_means.push_back(r);
		power_sum[idx] = '0;
		if (s.channel_index == nch - 1) packet_count[s.polarization] = '0;
	endfunction

	function automatic int draw_wait();
		return full_rate ? 0 : $urandom_range(0, 19);
	endfunction

	// Sends one sample item. Called at a falling edge, returns at one. The
	// valid line stays high on return so that back-to-back items need no
	// second assignment in the same time step.
	task automatic send_sample(input dppi_pkg::in_item_t s);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = s;
		do @(posedge clk); while (!in_ch.ready);
		integrate_sample(s);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [7:0] b, input logic pol, input int ch,
			input logic inval, input logic last);
		dppi_pkg::in_item_t s;
		s.sample_byte = b;
		s.polarization = pol;
		s.channel_index = dppi_pkg::CH_W'(ch);
		s.packet_invalid = inval;
		s.last_packet = last;
		send_sample(s);
	endtask

	// Waits until every expected mean has arrived, then lets the pipeline
	// settle, since dropped or non-reporting items may still be in flight.
	task automatic drain_results();
		in_ch.valid = 1'b0;
		while (expected_means.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the channel-count register. Only called with the block idle.
	task automatic set_channels(input int value);
		drain_results();
		cfg_we = 1'b1;
		cfg_wdata = dppi_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		channel_setting = dppi_pkg::CFG_W'(value);
	endtask

	// One well-formed integration: whole packets with channels in order, a
	// few marked invalid, and the last packet of one polarization reporting.
	task automatic run_integration(input logic pol, input int packets, input int bad_pct);
		int nch;
		logic inval;
		nch = used_channels();
		for (int p = 0; p < packets; p++) begin
			inval = ($urandom_range(0, 99) < bad_pct);
			for (int c = 0; c < nch; c++)
				send_fields(8'($urandom()), pol, c, inval, p == packets - 1);
		end
	endtask

	// Output side: a random stall before each result, none in full-rate stretches.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_wait();
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Result check at every rising edge that moves an item.
	always @(posedge clk) begin
		dppi_pkg::out_item_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			means_seen++;
			if (expected_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pol %0d ch %0d mean %0h flag %0b",
						got.out_polarization, got.out_channel, got.mean_power,
						got.no_valid_packets);
			end else begin
				want = expected_means.pop_front();
				if (got.out_polarization !== want.out_polarization
						|| got.out_channel !== want.out_channel
						|| got.mean_power !== want.mean_power
						|| got.no_valid_packets !== want.no_valid_packets) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected pol %0d ch %0d mean %0h flag %0b",
							want.out_polarization, want.out_channel, want.mean_power,
							want.no_valid_packets);
						$display("          actual   pol %0d ch %0d mean %0h flag %0b",
							got.out_polarization, got.out_channel, got.mean_power,
							got.no_valid_packets);
					end
				end
			end
		end
	end

	// Reset setting with the full 1024 channels: nibble extremes at both edge
	// channels, then a report of each edge channel of both polarizations.
	task automatic test_full_width_extremes();
		logic [7:0] bytes [6] = '{8'h00, 8'hFF, 8'h88, 8'h80, 8'h08, 8'h7F};
		foreach (bytes[i]) send_fields(bytes[i], 1'(i % 2), 0, 1'b0, 1'b0);
		foreach (bytes[i]) send_fields(bytes[i], 1'(i % 2), 1023, 1'b0, 1'b0);
		send_fields(8'h00, 1'b0, 1023, 1'b0, 1'b1);
		send_fields(8'hFF, 1'b1, 1023, 1'b0, 1'b1);
		send_fields(8'h0F, 1'b0, 0, 1'b0, 1'b1);
		send_fields(8'hF0, 1'b1, 0, 1'b1, 1'b1);
	endtask

	// A last packet with no valid packet counted reports zero with the flag.
	task automatic test_zero_count();
		set_channels(2);
		send_fields(8'h00, 1'b1, 0, 1'b1, 1'b1);
		send_fields(8'h00, 1'b1, 1, 1'b1, 1'b1);
		// An invalid last packet after a valid one still reports and clears.
		send_fields(8'h00, 1'b0, 0, 1'b0, 1'b0);
		send_fields(8'h11, 1'b0, 1, 1'b0, 1'b0);
		send_fields(8'hFF, 1'b0, 0, 1'b1, 1'b1);
		send_fields(8'hFF, 1'b0, 1, 1'b1, 1'b1);
	endtask

	// Out-of-range register values: zero acts as one channel, anything above
	// 1024 as 1024. Channels beyond the setting are dropped silently.
	task automatic test_register_range();
		set_channels(0);
		send_fields(8'h00, 1'b0, 1, 1'b0, 1'b1);
		send_fields(8'h00, 1'b0, 0, 1'b0, 1'b1);
		set_channels(2047);
		send_fields(8'hFF, 1'b1, 1023, 1'b0, 1'b1);
		set_channels(1025);
		send_fields(8'h80, 1'b0, 1023, 1'b0, 1'b1);
		set_channels(1);
		send_fields(8'h08, 1'b1, 512, 1'b0, 1'b1);
		send_fields(8'h08, 1'b1, 0, 1'b0, 1'b1);
	endtask

	// Random integrations at small channel counts, with noise items and full-rate
	// stretches, until the item budget is used.
	task automatic test_random_integrations();
		int pick;
		while (sent_items < 1750) begin
			full_rate = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// Noise at the full width so every channel bit toggles.
				set_channels(1024);
				repeat (20) send_fields(8'($urandom()), 1'($urandom()),
					$urandom_range(0, 1023), 1'($urandom()), $urandom_range(0, 3) == 0);
				// Close both polarizations so the counts restart cleanly.
				send_fields(8'($urandom()), 1'b0, 1023, 1'b1, 1'b1);
				send_fields(8'($urandom()), 1'b1, 1023, 1'b1, 1'b1);
			end else begin
				if (pick == 1) set_channels($urandom_range(0, 17));
				if (used_channels() > 32) set_channels($urandom_range(1, 16));
				run_integration(1'($urandom()), $urandom_range(1, 4), 15);
				if ($urandom_range(0, 3) == 0)
					send_fields(8'($urandom()), 1'($urandom()),
						used_channels() + $urandom_range(0, 7), 1'($urandom()), 1'b1);
			end
		end
		full_rate = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 2*dppi_pkg::MAX_CHANNELS; i++) power_sum[i] = '0;
		packet_count[0] = '0;
		packet_count[1] = '0;
		channel_setting = dppi_pkg::CFG_W'(dppi_pkg::MAX_CHANNELS);
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_full_width_extremes();
		test_zero_count();
		test_register_range();
		test_random_integrations();
		drain_results();
		$display("Sent %0d sample items and checked %0d mean-power items.", sent_items,
			means_seen);
		$display("Zero-count reports: %0d, saturated means: %0d, mismatches: %0d.",
			zero_count_means, saturated_means, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Far beyond the slowest correct run: clearing pass plus every item at the
	// longest gap, longest stall and full divider time.
	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/dppi_pkg.sv
hdl/dppi_if.sv
hdl/dppi_front.sv
hdl/dppi_div.sv
hdl/dppi_back.sv
hdl/dual_pol_power_integrator.sv
verif/tb_dual_pol_power_integrator.sv
